@@ rtl/core/msched_pkg.sv @@
// Shared types, constants and codes for the multilevel priority scheduler.
package msched_pkg;

    // Sizes of the scheduler state
    localparam int MAX_LEVELS = 16;
    localparam int TASK_IDS   = 64;
    localparam int LEVEL_W    = $clog2(MAX_LEVELS);
    localparam int ID_W       = $clog2(TASK_IDS);
    localparam int QUEUES     = 2 * MAX_LEVELS;
    localparam int QADDR_W    = LEVEL_W + 1;

    // Field widths fixed by the interface
    localparam int CFG_W      = 5;
    localparam int PRIO_W     = 5;
    localparam int STATUS_W   = 2;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [CFG_W-1:0] LEVELS_RESET = 5'd4;
    localparam logic REG_LEVELS = 1'b0;

    // Front to back queue depth
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Command codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_DUP   = 2'd3
    } status_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic               is_get;
        logic               expired;
        logic               range_err;
        logic [ID_W-1:0]    task_id;
        logic [LEVEL_W-1:0] level;
    } item_t;

    // One result item
    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    task_id;
        logic [LEVEL_W-1:0] level;
        logic               swapped;
    } result_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EXEC,
        B_ADD_LINK,
        B_GET_RD,
        B_GET_UPD,
        B_OUT
    } back_state_t;

endpackage

@@ rtl/core/multilevel_priority_scheduler.sv @@
// Multilevel priority scheduler: top level with configuration register.
//
// Commands enter on the input channel (in_valid/in_ready): command 0 adds
// task_id at dyn_priority, or at static_priority - 1 in the expired bank when
// dyn_priority is -1; command 1 pops the head of the highest non-empty
// active level, swapping banks first when the active bank is empty.
// Every item gives exactly one result on the output channel
// (out_valid/out_ready): status, task_out, level_out, swapped.
// An item is taken into a two-entry queue on acceptance. The sequencer
// passes idle, execute and output states; a failed or first-in-level add or
// a get on empty banks needs no more, an add behind a tail adds a link state
// and a get that pops adds read and update states for the memory reads.
// It takes a new item only once the last result is in the output register.
// A finished result waits in the output register while the receiver stalls;
// the input queue keeps accepting until it is full.
// levels_in_use is written over the APB port at address 0, reset value 4.
// Reset empties every queue, selects bank 0 as active and clears the
// queued-task flags; no clearing pass is needed.
module multilevel_priority_scheduler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [msched_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [msched_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [msched_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready,
    // Command channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  command,
    input  logic [msched_pkg::ID_W-1:0]           task_id,
    input  logic signed [msched_pkg::PRIO_W-1:0]  dyn_priority,
    input  logic [msched_pkg::PRIO_W-1:0]         static_priority,
    // Result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [msched_pkg::STATUS_W-1:0]       status,
    output logic [msched_pkg::ID_W-1:0]           task_out,
    output logic [msched_pkg::LEVEL_W-1:0]        level_out,
    output logic                                  swapped
);
    import msched_pkg::*;

    logic [CFG_W-1:0] levels_reg;
    logic             reg_index;
    logic             cfg_write;

    logic    fifo_push, fifo_pop, fifo_full, fifo_empty;
    item_t   front_item, back_item;
    result_t result;

    // Configuration register
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            levels_reg <= LEVELS_RESET;
        else if (cfg_write && (reg_index == REG_LEVELS))
            levels_reg <= pwdata[CFG_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_LEVELS)
            prdata = APB_DATA_W'(levels_reg);
    end

    msched_front u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .task_id         (task_id),
        .dyn_priority    (dyn_priority),
        .static_priority (static_priority),
        .levels_in_use   (levels_reg),
        .fifo_full       (fifo_full),
        .fifo_push       (fifo_push),
        .fifo_item       (front_item)
    );

    msched_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_item (front_item),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_item  (back_item),
        .empty     (fifo_empty)
    );

    msched_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_item  (back_item),
        .fifo_pop   (fifo_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (result)
    );

    // Result fields
    assign status    = result.status;
    assign task_out  = result.task_id;
    assign level_out = result.level;
    assign swapped   = result.swapped;

endmodule

@@ rtl/core/msched_front.sv @@
// Front end: input handshake and classification of add and get commands.
module msched_front (
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           command,
    input  logic [msched_pkg::ID_W-1:0]    task_id,
    input  logic signed [msched_pkg::PRIO_W-1:0] dyn_priority,
    input  logic [msched_pkg::PRIO_W-1:0]  static_priority,
    input  logic [msched_pkg::CFG_W-1:0]   levels_in_use,
    input  logic                           fifo_full,
    output logic                           fifo_push,
    output msched_pkg::item_t              fifo_item
);
    import msched_pkg::*;

    logic [CFG_W-1:0]  lim;
    logic [PRIO_W-1:0] prio;
    logic              expired;
    logic              negative;

    // Handshake: take an item whenever the queue has room
    assign in_ready  = !fifo_full;
    assign fifo_push = in_valid && !fifo_full;

    // Level limit saturates at the number of levels built
    assign lim = (levels_in_use > CFG_W'(MAX_LEVELS)) ? CFG_W'(MAX_LEVELS) : levels_in_use;

    // Expired requeue uses static priority minus one
    assign expired  = (dyn_priority == -PRIO_W'(1));
    assign prio     = expired ? (static_priority - PRIO_W'(1)) : PRIO_W'(dyn_priority);
    assign negative = expired ? (static_priority == '0) : dyn_priority[PRIO_W-1];

    // Classified item
    always_comb
    begin
        fifo_item.is_get    = (command == CMD_GET);
        fifo_item.expired   = expired;
        fifo_item.range_err = negative || (CFG_W'(prio) >= lim);
        fifo_item.task_id   = task_id;
        fifo_item.level     = prio[LEVEL_W-1:0];
    end

endmodule

@@ rtl/core/msched_fifo.sv @@
// Short queue of classified items between the front and back ends.
module msched_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  msched_pkg::item_t push_item,
    output logic              full,
    input  logic              pop,
    output msched_pkg::item_t pop_item,
    output logic              empty
);
    import msched_pkg::*;

    item_t                 slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + FIFO_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + FIFO_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - FIFO_CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/core/msched_back.sv @@
// Back end: linked-list queues, bank swap, push and pop sequencer, result register.
module msched_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fifo_empty,
    input  msched_pkg::item_t    fifo_item,
    output logic                 fifo_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output msched_pkg::result_t  out_result
);
    import msched_pkg::*;

    // Queue memories
    logic [ID_W-1:0] link_mem [TASK_IDS];
    logic [ID_W-1:0] head_mem [QUEUES];
    logic [ID_W-1:0] tail_mem [QUEUES];

    back_state_t                   state_reg, state_next;
    item_t                         cur_reg, cur_next;
    result_t                       res_reg, res_next;
    result_t                       out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;
    logic [QADDR_W-1:0]            q_reg, q_next;
    logic                          active_reg, active_next;
    logic [1:0][MAX_LEVELS-1:0]    nonempty_reg, nonempty_next;
    logic [TASK_IDS-1:0]           queued_reg, queued_next;

    logic [ID_W-1:0] head_rd_reg, tail_rd_reg, link_rd_reg;
    logic            ht_re, link_re;
    logic            head_we, tail_we, link_we;
    logic [ID_W-1:0] head_wdata;

    logic                  bank;
    logic                  get_bank;
    logic [MAX_LEVELS-1:0] get_vec;
    logic [LEVEL_W-1:0]    top_level;

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Highest non-empty level of the bank a get works on
    assign get_bank = (nonempty_reg[active_reg] == '0) ? !active_reg : active_reg;
    assign get_vec  = nonempty_reg[get_bank];
    always_comb
    begin
        top_level = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (get_vec[i])
                top_level = LEVEL_W'(i);
        end
    end

    // Bank an add goes to
    assign bank = active_reg ^ cur_reg.expired;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        q_next         = q_reg;
        active_next    = active_reg;
        nonempty_next  = nonempty_reg;
        queued_next    = queued_reg;
        fifo_pop       = 1'b0;
        ht_re          = 1'b0;
        link_re        = 1'b0;
        head_we        = 1'b0;
        tail_we        = 1'b0;
        link_we        = 1'b0;
        head_wdata     = cur_reg.task_id;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop   = 1'b1;
                    cur_next   = fifo_item;
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                res_next.status  = ST_OK;
                res_next.task_id = '0;
                res_next.level   = '0;
                res_next.swapped = 1'b0;
                if (cur_reg.is_get)
                begin
                    if (nonempty_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                        state_next      = B_OUT;
                    end
                    else
                    begin
                        active_next      = get_bank;
                        res_next.swapped = (get_bank != active_reg);
                        res_next.level   = top_level;
                        q_next           = {get_bank, top_level};
                        ht_re            = 1'b1;
                        state_next       = B_GET_RD;
                    end
                end
                else
                begin
                    res_next.task_id = cur_reg.task_id;
                    q_next           = {bank, cur_reg.level};
                    if (cur_reg.range_err)
                    begin
                        res_next.status = ST_RANGE;
                        state_next      = B_OUT;
                    end
                    else if (queued_reg[cur_reg.task_id])
                    begin
                        res_next.status = ST_DUP;
                        state_next      = B_OUT;
                    end
                    else if (nonempty_reg[bank][cur_reg.level])
                    begin
                        // Non-empty queue: fetch the tail to link behind it
                        res_next.level = cur_reg.level;
                        ht_re          = 1'b1;
                        state_next     = B_ADD_LINK;
                    end
                    else
                    begin
                        // Empty queue: the task becomes head and tail
                        res_next.level = cur_reg.level;
                        head_we        = 1'b1;
                        tail_we        = 1'b1;
                        nonempty_next[bank][cur_reg.level] = 1'b1;
                        queued_next[cur_reg.task_id]       = 1'b1;
                        state_next     = B_OUT;
                    end
                end
            end
            B_ADD_LINK:
            begin
                link_we    = 1'b1;
                tail_we    = 1'b1;
                queued_next[cur_reg.task_id] = 1'b1;
                state_next = B_OUT;
            end
            B_GET_RD:
            begin
                link_re    = 1'b1;
                state_next = B_GET_UPD;
            end
            B_GET_UPD:
            begin
                // Pop the head; the last entry empties the level
                if (head_rd_reg == tail_rd_reg)
                    nonempty_next[q_reg[QADDR_W-1]][q_reg[LEVEL_W-1:0]] = 1'b0;
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = link_rd_reg;
                end
                queued_next[head_rd_reg] = 1'b0;
                res_next.task_id         = head_rd_reg;
                state_next               = B_OUT;
            end
            B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            nonempty_reg  <= '0;
            queued_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            nonempty_reg  <= nonempty_next;
            queued_reg    <= queued_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        out_reg <= out_next;
        q_reg   <= q_next;
    end

    // Head and tail memories
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[q_next] <= head_wdata;
        if (tail_we)
            tail_mem[q_next] <= cur_reg.task_id;
        if (ht_re)
        begin
            head_rd_reg <= head_mem[q_next];
            tail_rd_reg <= tail_mem[q_next];
        end
    end

    // Next-link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[tail_rd_reg] <= cur_reg.task_id;
        if (link_re)
            link_rd_reg <= link_mem[head_rd_reg];
    end

    // No task is marked queued while every level is empty
    a_empty_none_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty_reg == '0) |-> (queued_reg == '0))
        else $error("task marked queued with all levels empty");

    // A pop always works on a non-empty level
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_GET_UPD) |-> nonempty_reg[q_reg[QADDR_W-1]][q_reg[LEVEL_W-1:0]])
        else $error("pop from an empty level");

    // The popped head is a queued task
    a_pop_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_GET_UPD) |-> queued_reg[head_rd_reg])
        else $error("popped head not marked queued");

    // Linking behind a tail only happens on a non-empty level
    a_link_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ADD_LINK) |-> nonempty_reg[q_reg[QADDR_W-1]][q_reg[LEVEL_W-1:0]])
        else $error("tail link on an empty level");

endmodule
